@@ src/pdma_pkg.sv @@
// ============================================================================
// pdma_pkg: shared constants and types of the pointer delta moving average
// Holds the window size, the field and sum widths and the sequencer states.
// ============================================================================
package pdma_pkg;

    localparam int WINDOW      = 10;
    localparam int DELTA_WIDTH = 16;

    // Slot index into the history memory.
    localparam int SLOT_WIDTH  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    // The fill count must be able to hold WINDOW itself.
    localparam int CNT_WIDTH   = $clog2(WINDOW + 1);
    // A sum of WINDOW signed deltas never wraps at this width.
    localparam int SUM_WIDTH   = DELTA_WIDTH + CNT_WIDTH;
    // Counts the quotient bits of the shift-subtract divider.
    localparam int STEP_WIDTH  = $clog2(SUM_WIDTH);
    // One history entry holds an x and a y delta.
    localparam int ENTRY_WIDTH = 2 * DELTA_WIDTH;

    typedef logic signed [DELTA_WIDTH-1:0] t_delta;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

endpackage

@@ src/pdma_if.sv @@
// ============================================================================
// pdma_if: valid/ready channels of the pointer delta moving average
// pdma_in_if carries one delta pair, pdma_out_if one pair of averages.
// ============================================================================
interface pdma_in_if;
    logic              valid;
    logic              ready;
    pdma_pkg::t_delta  delta_x;
    pdma_pkg::t_delta  delta_y;

    modport source (output valid, output delta_x, output delta_y, input ready);
    modport sink   (input valid, input delta_x, input delta_y, output ready);
endinterface

interface pdma_out_if;
    logic              valid;
    logic              ready;
    pdma_pkg::t_delta  avg_x;
    pdma_pkg::t_delta  avg_y;

    modport source (output valid, output avg_x, output avg_y, input ready);
    modport sink   (input valid, input avg_x, input avg_y, output ready);
endinterface

@@ src/pdma_ram.sv @@
// ============================================================================
// pdma_ram: generic single-port RAM with registered read
// One address serves the write and the read; read data is registered and appears in the next cycle.
// ============================================================================
module pdma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                           i_wdata,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/pointer_delta_moving_average_top.sv @@
// ============================================================================
// pointer_delta_moving_average_top: windowed mean of pointer movements
// Keeps the last WINDOW delta pairs in RAM, emits truncated means if nonzero.
// ============================================================================
//
//  Channel  | Dir | Payload            | Transfer when
//  ---------+-----+--------------------+------------------------------
//  i_in     | in  | delta_x, delta_y   | i_in.valid && i_in.ready
//  o_out    | out | avg_x, avg_y       | o_out.valid && o_out.ready
//
// Each pair passes the sequencer before the next is taken: the accepting
// edge takes it and reads the oldest entry, the load step updates the
// running sums and writes the new pair, the shift-subtract divider makes
// one quotient bit per cycle (x, y in parallel lanes), then the emit step.
// A synchronous active-low reset clears the sums, the slot pointer, the fill
// count and the output register; the history RAM is not cleared.
// A result waiting in the output register does not block the next input
// transfer; only the emit step waits until that register is free.
//
module pointer_delta_moving_average_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pdma_in_if.sink     i_in,
    pdma_out_if.source  o_out
);

    localparam int DW = pdma_pkg::DELTA_WIDTH;
    localparam int SW = pdma_pkg::SUM_WIDTH;
    localparam int CW = pdma_pkg::CNT_WIDTH;

    // Divider lane: partial remainder and the shifting dividend/quotient.
    typedef struct packed {
        logic [CW-1:0] rem;
        logic [SW-1:0] quo;
    } t_lane;

    // One restoring division step: shift in the next dividend bit and
    // subtract the divisor when it fits.
    function automatic t_lane div_step(input t_lane lane, input logic [CW-1:0] divisor);
        logic [CW:0] shifted;
        logic [CW:0] diff;
        t_lane       res;
        shifted = {lane.rem, lane.quo[SW-1]};
        diff    = shifted - {1'b0, divisor};
        if (shifted >= {1'b0, divisor}) begin
            res.rem = diff[CW-1:0];
            res.quo = {lane.quo[SW-2:0], 1'b1};
        end else begin
            res.rem = shifted[CW-1:0];
            res.quo = {lane.quo[SW-2:0], 1'b0};
        end
        return res;
    endfunction

    pdma_pkg::t_state r_state, n_state;

    logic [pdma_pkg::SLOT_WIDTH-1:0] r_slot;
    logic [CW-1:0]                   r_fill;
    logic signed [SW-1:0]            r_sum_x, r_sum_y;
    logic [pdma_pkg::STEP_WIDTH-1:0] r_step;
    t_lane                           r_lane_x, r_lane_y;
    pdma_pkg::t_delta                r_dx, r_dy;
    logic                            r_out_valid;
    pdma_pkg::t_delta                r_avg_x, r_avg_y;

    logic                            in_xfer;
    logic                            out_free;
    logic                            ram_we;
    logic [pdma_pkg::ENTRY_WIDTH-1:0] ram_rdata;
    logic signed [SW-1:0]            old_x, old_y;
    logic signed [SW-1:0]            n_sum_x, n_sum_y;
    logic [SW-1:0]                   mag_x, mag_y;
    t_lane                           step_x, step_y;
    logic [SW-1:0]                   res_x, res_y;
    logic                            res_nonzero;

    // The history RAM holds {x, y}; it is always addressed at the current slot,
    // read on the accepting edge and written back during the load step.
    pdma_ram #(
        .WIDTH (pdma_pkg::ENTRY_WIDTH),
        .DEPTH (pdma_pkg::WINDOW)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (r_slot),
        .i_wdata ({r_dx, r_dy}),
        .o_rdata (ram_rdata)
    );

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pdma_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    n_state = pdma_pkg::ST_LOAD;
                end
            end
            pdma_pkg::ST_LOAD: begin
                n_state = pdma_pkg::ST_DIVIDE;
            end
            pdma_pkg::ST_DIVIDE: begin
                if (r_step == '0) begin
                    n_state = pdma_pkg::ST_EMIT;
                end
            end
            pdma_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = pdma_pkg::ST_IDLE;
                end
            end
            default: n_state = pdma_pkg::ST_IDLE;
        endcase
    end

    // State-decoded outputs.
    always_comb begin
        i_in.ready = 1'b0;
        ram_we     = 1'b0;
        unique case (r_state)
            pdma_pkg::ST_IDLE:   i_in.ready = 1'b1;
            pdma_pkg::ST_LOAD:   ram_we     = 1'b1;
            pdma_pkg::ST_DIVIDE: ;
            pdma_pkg::ST_EMIT:   ;
            default: ;
        endcase
    end

    // Sum update. The oldest entry only leaves once the window is full, so an
    // entry that was never written is never used.
    always_comb begin
        old_x = '0;
        old_y = '0;
        if (r_fill == CW'(pdma_pkg::WINDOW)) begin
            old_x = {{(SW-DW){ram_rdata[2*DW-1]}}, ram_rdata[2*DW-1:DW]};
            old_y = {{(SW-DW){ram_rdata[DW-1]}}, ram_rdata[DW-1:0]};
        end
        n_sum_x = r_sum_x - old_x + {{(SW-DW){r_dx[DW-1]}}, r_dx};
        n_sum_y = r_sum_y - old_y + {{(SW-DW){r_dy[DW-1]}}, r_dy};
        mag_x   = n_sum_x[SW-1] ? SW'(-n_sum_x) : SW'(n_sum_x);
        mag_y   = n_sum_y[SW-1] ? SW'(-n_sum_y) : SW'(n_sum_y);
    end

    assign step_x = div_step(r_lane_x, r_fill);
    assign step_y = div_step(r_lane_y, r_fill);

    // Quotients truncate toward zero, so the sign of the sum is put back.
    assign res_x       = r_sum_x[SW-1] ? (~r_lane_x.quo + 1'b1) : r_lane_x.quo;
    assign res_y       = r_sum_y[SW-1] ? (~r_lane_y.quo + 1'b1) : r_lane_y.quo;
    assign res_nonzero = (r_lane_x.quo != '0) || (r_lane_y.quo != '0);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdma_pkg::ST_IDLE;
            r_slot      <= '0;
            r_fill      <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == pdma_pkg::ST_LOAD) begin
                r_sum_x <= n_sum_x;
                r_sum_y <= n_sum_y;
                if (r_fill != CW'(pdma_pkg::WINDOW)) begin
                    r_fill <= r_fill + 1'b1;
                end
                if (r_slot == pdma_pkg::SLOT_WIDTH'(pdma_pkg::WINDOW - 1)) begin
                    r_slot <= '0;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
                r_step <= pdma_pkg::STEP_WIDTH'(SW - 1);
            end else if (r_state == pdma_pkg::ST_DIVIDE) begin
                r_step <= r_step - 1'b1;
            end
            if (r_state == pdma_pkg::ST_EMIT && out_free) begin
                r_out_valid <= res_nonzero;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_dx <= i_in.delta_x;
            r_dy <= i_in.delta_y;
        end
        if (r_state == pdma_pkg::ST_LOAD) begin
            r_lane_x <= '{rem: '0, quo: mag_x};
            r_lane_y <= '{rem: '0, quo: mag_y};
        end else if (r_state == pdma_pkg::ST_DIVIDE) begin
            r_lane_x <= step_x;
            r_lane_y <= step_y;
        end
        if (r_state == pdma_pkg::ST_EMIT && out_free) begin
            r_avg_x <= res_x[DW-1:0];
            r_avg_y <= res_y[DW-1:0];
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.avg_x = r_avg_x;
    assign o_out.avg_y = r_avg_y;

endmodule
